// File: hdl/box_blur_3x3_rgb_core_macros.svh
// assertion helpers for the box blur checker
`ifndef BOX_BLUR_3X3_RGB_CORE_MACROS_SVH
`define BOX_BLUR_3X3_RGB_CORE_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define BBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// next-cycle implication built on the plain form
`define BBR_ASSERT_NEXT(label, ante, cons, msg) \
  `BBR_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: hdl/bbr_pkg.sv
`default_nettype none

package bbr_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int DIM_W       = 13;
  localparam int ROW_W       = DIM_W + 1;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = $clog2(9 * 255 + 1);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bbr_reg_e;

  // which neighbours of the centre pixel lie inside the frame, and whether it ends the frame
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic frame_end;
  } bbr_edge_t;

  function automatic logic [WID_W-1:0] eff_width(logic [DIM_W-1:0] v);
    logic [WID_W-1:0] w;
    if (v == '0) begin
      w = WID_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(v);
    end
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // ceil(2^RECIP_SHIFT / n) for the possible neighbour counts
  function automatic logic [RECIP_W-1:0] mean_recip(logic [3:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd2:    r = RECIP_W'(((2 ** RECIP_SHIFT) + 1) / 2);
      4'd3:    r = RECIP_W'(((2 ** RECIP_SHIFT) + 2) / 3);
      4'd4:    r = RECIP_W'(((2 ** RECIP_SHIFT) + 3) / 4);
      4'd6:    r = RECIP_W'(((2 ** RECIP_SHIFT) + 5) / 6);
      4'd9:    r = RECIP_W'(((2 ** RECIP_SHIFT) + 8) / 9);
      default: r = RECIP_W'(2 ** RECIP_SHIFT);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bbr_line_ram.sv
`default_nettype none

module bbr_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/box_blur_3x3_rgb_core.sv
// 3x3 mean blur over an rgb888 raster stream. pixels arrive in raster order for a frame
// of frame_width by frame_height; each output pixel is, per channel, the floor of the mean
// of the in-frame pixels of the 3x3 window around it (9 inside, 6 on edges, 4 in corners).
// results lag the input by one row plus one pixel, so after the last pixel of a frame
// the user sends drain items (kind_i high) to push out the tail; frame_end_o marks the
// last output pixel, after which the next pixel starts a new frame. a drain sent before
// the last pixel, or a pixel sent while the tail is pending, is taken and dropped. a
// configuration write restarts the frame at once. one item is taken per clock while
// results are being taken; an item passes from its transfer through stage 1, the line
// memory read and the window sum, and stage 2, the reciprocal multiply, into the output
// register. the line memory is not cleared after reset: the edge rules keep every entry
// that has not been written in the current frame out of the sums.
`default_nettype none

module box_blur_3x3_rgb_core
  import bbr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [DIM_W-1:0] cfg_wdata_i,
  // input items
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             kind_i,
  input  wire logic [CH_W-1:0]  red_in_i,
  input  wire logic [CH_W-1:0]  green_in_i,
  input  wire logic [CH_W-1:0]  blue_in_i,
  // result items
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [CH_W-1:0]  red_out_o,
  output logic      [CH_W-1:0]  green_out_o,
  output logic      [CH_W-1:0]  blue_out_o,
  output logic                  frame_end_o
);

  // ---------------------------------------------------------------------------
  // configuration and position counters
  // ---------------------------------------------------------------------------
  logic [WID_W-1:0] eff_w_q;
  logic [DIM_W-1:0] eff_h_q;
  logic [COL_W-1:0] in_column_q;
  logic [ROW_W-1:0] in_row_q;
  logic [COL_W-1:0] out_column_q;
  logic [DIM_W-1:0] out_row_q;

  // the whole pipe moves together whenever the output register can take a result
  logic advance;
  logic accept;
  logic ignore;
  logic take;
  logic produce;
  logic in_last_col;
  bbr_edge_t edge_d;

  assign advance    = ~out_valid_o | out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i & advance;

  // drains only count once the frame's pixels are in; pixels only before that
  assign ignore = kind_i ? (in_row_q < ROW_W'(eff_h_q)) : (in_row_q >= ROW_W'(eff_h_q));
  assign take   = accept & ~ignore;

  // first result appears once one row plus one pixel has gone in
  assign produce = (in_row_q > ROW_W'(1)) || ((in_row_q == ROW_W'(1)) && (in_column_q != '0));

  assign in_last_col = (WID_W'(in_column_q) + WID_W'(1)) >= eff_w_q;

  always_comb begin
    edge_d.left      = (out_column_q != '0);
    edge_d.right     = (WID_W'(out_column_q) + WID_W'(1)) < eff_w_q;
    edge_d.top       = (out_row_q != '0);
    edge_d.bottom    = (out_row_q + DIM_W'(1)) < eff_h_q;
    edge_d.frame_end = ~edge_d.right & ~edge_d.bottom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q      <= eff_width(WIDTH_RESET);
      eff_h_q      <= eff_height(HEIGHT_RESET);
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
    end else if (cfg_we_i) begin
      case (bbr_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  eff_w_q <= eff_width(cfg_wdata_i);
        REG_FRAME_HEIGHT: eff_h_q <= eff_height(cfg_wdata_i);
        default: ;
      endcase
      // any write restarts the frame
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
    end else if (take) begin
      if (produce && edge_d.frame_end) begin
        // last output of the frame: everything back to the start
        in_column_q  <= '0;
        in_row_q     <= '0;
        out_column_q <= '0;
        out_row_q    <= '0;
      end else begin
        if (in_last_col) begin
          in_column_q <= '0;
          in_row_q    <= in_row_q + ROW_W'(1);
        end else begin
          in_column_q <= in_column_q + COL_W'(1);
        end
        if (produce) begin
          if (!edge_d.right) begin
            out_column_q <= '0;
            out_row_q    <= out_row_q + DIM_W'(1);
          end else begin
            out_column_q <= out_column_q + COL_W'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line memory read data, write-back and window
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_produce_q;
  bbr_edge_t        s1_edge_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic             fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] store;
  logic [PIX_W-1:0]   line_a;
  logic [PIX_W-1:0]   line_b;
  logic [2*PIX_W-1:0] wr_data;
  logic               s1_write;

  // memory word is {row before last, last row} at each column
  bbr_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PIX_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (take),
    .raddr_i (in_column_q),
    .rdata_o (ram_rdata)
  );

  // a one-pixel-wide frame reads the column that stage 1 is writing right now
  assign store    = fwd_q ? fwd_data_q : ram_rdata;
  assign line_b   = store[2*PIX_W-1:PIX_W];
  assign line_a   = store[PIX_W-1:0];
  assign wr_data  = {line_a, s1_pix_q};
  assign s1_write = advance & s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= take;
      fwd_q      <= s1_valid_q & (s1_col_q == in_column_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_produce_q <= produce;
      s1_edge_q    <= edge_d;
      s1_pix_q     <= kind_i ? '0 : {red_in_i, green_in_i, blue_in_i};
      s1_col_q     <= in_column_q;
      fwd_data_q   <= wr_data;
    end
  end

  // window laid out as column * 3 + row, column 0 on the left, row 0 on top
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i+3];
    end
    win_d[6] = line_b;
    win_d[7] = line_a;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      win_q <= win_d;
    end
  end

  // masked sums over the new window
  logic [2:0]       col_use;
  logic [2:0]       row_use;
  logic [8:0]       tap_use;
  logic [SUM_W-1:0] sum_d [3];
  logic [1:0]       ncols;
  logic [1:0]       nrows;
  logic [3:0]       cnt;

  always_comb begin
    col_use = {s1_edge_q.right, 1'b1, s1_edge_q.left};
    row_use = {s1_edge_q.bottom, 1'b1, s1_edge_q.top};
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        tap_use[c*3+r] = col_use[c] & row_use[r];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (tap_use[k]) begin
          sum_d[ch] = sum_d[ch] + SUM_W'(win_d[k][(2-ch)*CH_W +: CH_W]);
        end
      end
    end
    ncols = 2'd1 + {1'b0, s1_edge_q.left} + {1'b0, s1_edge_q.right};
    nrows = 2'd1 + {1'b0, s1_edge_q.top} + {1'b0, s1_edge_q.bottom};
    cnt   = {2'b00, ncols} * {2'b00, nrows};
  end

  // ---------------------------------------------------------------------------
  // stage 2: divide by the neighbour count through its reciprocal
  // ---------------------------------------------------------------------------
  logic               s2_valid_q;
  logic [SUM_W-1:0]   s2_sum_q [3];
  logic [RECIP_W-1:0] s2_recip_q;
  logic               s2_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q & s1_produce_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_sum_q   <= sum_d;
      s2_recip_q <= mean_recip(cnt);
      s2_fe_q    <= s1_edge_q.frame_end;
    end
  end

  logic [SUM_W+RECIP_W-1:0] prod [3];
  logic [CH_W-1:0]          mean [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (SUM_W + RECIP_W)'(s2_sum_q[ch]) * (SUM_W + RECIP_W)'(s2_recip_q);
      mean[ch] = prod[ch][RECIP_SHIFT +: CH_W];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic            out_valid_q;
  logic [CH_W-1:0] red_q;
  logic [CH_W-1:0] green_q;
  logic [CH_W-1:0] blue_q;
  logic            frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_q       <= mean[0];
      green_q     <= mean[1];
      blue_q      <= mean[2];
      frame_end_q <= s2_fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// File: hdl/bbr_checker.sv
`default_nettype none
`include "box_blur_3x3_rgb_core_macros.svh"

module bbr_checker
  import bbr_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [CH_W-1:0]  red_out_o,
  input wire logic [CH_W-1:0]  green_out_o,
  input wire logic [CH_W-1:0]  blue_out_o,
  input wire logic             frame_end_o
);

  // input is held back only by a result that is not being taken
  `BBR_ASSERT(ready_tracks_output, in_ready_o == (!out_valid_o || out_ready_i), "input stalled without an output stall")

  // a new result only lands when the pipe moved in the cycle before
  `BBR_ASSERT(result_needs_advance, $rose(out_valid_o) |-> $past(in_ready_o), "result loaded while stalled")

  // a stalled result keeps its value until the transfer
  `BBR_ASSERT_NEXT(result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o), "stalled result changed")

endmodule

bind box_blur_3x3_rgb_core bbr_checker u_bbr_checker (.*);

`default_nettype wire

// File: sim/tb_box_blur_3x3_rgb_core.sv
module tb_box_blur_3x3_rgb_core
  import bbr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles allowed before the run is declared hung
  localparam int unsigned STALL_LIMIT = 1000;
  // cycles to let the pipeline empty before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 8;
  // accepted non-ignored items per idling phase
  localparam int unsigned PHASE_ITEMS = 550;
  // receiver hold-off length and how often it is triggered
  localparam int unsigned HOLD_CYCLES = 160;
  localparam int unsigned HOLD_EVERY = 600;

  typedef enum logic {
    PIXEL_ITEM = 1'b0,
    DRAIN_ITEM = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_px_t;

  // mirrors the line stores, window and raster counters, and keeps the
  // blurred pixels still owed by the block in arrival order
  class mean_blur_board;
    logic [PIX_W-1:0] row_prev  [MAX_WIDTH];
    logic [PIX_W-1:0] row_older [MAX_WIDTH];
    logic [PIX_W-1:0] win       [9];
    int unsigned      in_col, in_row, out_col, out_row;
    logic [DIM_W-1:0] width_reg, height_reg;
    blur_px_t         pending[$];
    int unsigned      mismatches;

    function new();
      foreach (row_prev[i]) begin
        row_prev[i]  = '0;
        row_older[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned cols_in_use();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int unsigned rows_in_use();
      return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    function void apply_reg(bbr_reg_e idx, logic [DIM_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    // returns 1 when the item is taken into the raster, 0 when dropped
    function bit take_item(logic drain, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
      int unsigned      w, h, total, count, n, cnt, sum_r, sum_g, sum_b;
      int               i, c, k;
      logic [PIX_W-1:0] pix, p;
      blur_px_t         px;
      w     = cols_in_use();
      h     = rows_in_use();
      total = w * h;
      count = in_row * w + in_col;
      if (drain ? (count < total) : (count >= total)) return 0;
      pix = drain ? '0 : {r, g, b};
      for (i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6]            = row_older[in_col];
      win[7]            = row_prev[in_col];
      win[8]            = pix;
      row_older[in_col] = row_prev[in_col];
      row_prev[in_col]  = pix;
      n = count;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (n < w + 1) return 1;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = 0;
      for (c = 0; c < 3; c++) begin
        if (c == 0 && out_col == 0) continue;
        if (c == 2 && out_col + 1 >= w) continue;
        for (k = 0; k < 3; k++) begin
          if (k == 0 && out_row == 0) continue;
          if (k == 2 && out_row + 1 >= h) continue;
          p = win[c * 3 + k];
          sum_r += 32'(p[23:16]);
          sum_g += 32'(p[15:8]);
          sum_b += 32'(p[7:0]);
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      px.red   = CH_W'(sum_r / cnt);
      px.green = CH_W'(sum_g / cnt);
      px.blue  = CH_W'(sum_b / cnt);
      if (out_row + 1 >= h && out_col + 1 >= w) begin
        px.frame_end = 1'b1;
        restart();
      end else begin
        px.frame_end = 1'b0;
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      pending.push_back(px);
      return 1;
    endfunction

    function void check_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                              logic fe);
      blur_px_t want;
      if (pending.size() == 0) begin
        $error("output pixel with none outstanding: r=%0d g=%0d b=%0d frame_end=%0b",
               r, g, b, fe);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (want.red !== r) begin
        $error("red_out: expected %0d, actual %0d", want.red, r);
        mismatches++;
      end
      if (want.green !== g) begin
        $error("green_out: expected %0d, actual %0d", want.green, g);
        mismatches++;
      end
      if (want.blue !== b) begin
        $error("blue_out: expected %0d, actual %0d", want.blue, b);
        mismatches++;
      end
      if (want.frame_end !== fe) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, fe);
        mismatches++;
      end
    endfunction
  endclass

  // clock, reset and everything the block sees, all known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_index_i = 1'b0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             kind_i      = 1'b0;
  logic [CH_W-1:0]  red_in_i    = '0;
  logic [CH_W-1:0]  green_in_i  = '0;
  logic [CH_W-1:0]  blue_in_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [CH_W-1:0]  red_out_o;
  logic [CH_W-1:0]  green_out_o;
  logic [CH_W-1:0]  blue_out_o;
  logic             frame_end_o;

  mean_blur_board blur_board;

  // idling odds in percent, changed by the stimulus at phase boundaries
  int unsigned send_gap_pct = 26;
  int unsigned recv_gap_pct = 58;
  // items that actually entered the raster (dropped ones are not counted)
  int unsigned items_used   = 0;
  int unsigned pixels_seen  = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  box_blur_3x3_rgb_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  // result side: check every transfer, then decide ready for the next edge.
  // every so often the receiver holds off for a long stretch so the line
  // pipeline backs up and the input side has to stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      blur_board.check_pixel(red_out_o, green_out_o, blue_out_o, frame_end_o);
      pixels_seen++;
      if (pixels_seen % HOLD_EVERY == HOLD_EVERY / 4) hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // hang detection: any cycle with a transfer on either side rearms it
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("box_blur_3x3_rgb_core regression: fail");
      $finish;
    end
  end

  // mostly random channels, with the two extremes turning up often
  function automatic logic [CH_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CH_W'($urandom);
  endfunction

  // offer one item, possibly after a random gap, and hold it until transfer.
  // valid is left high so a following item goes out back to back
  task automatic send_item(input item_kind_e kind, input logic [CH_W-1:0] r,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (blur_board.take_item(kind == DRAIN_ITEM, r, g, b)) items_used++;
  endtask

  // stop offering, let every owed pixel arrive and the pipeline run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blur_board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both size registers back to back, in random order, while idle
  task automatic set_frame_size(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val);
    bbr_reg_e first, second;
    settle();
    first  = $urandom_range(1) ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH;
    second = (first == REG_FRAME_WIDTH) ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= first;
    cfg_wdata_i <= (first == REG_FRAME_WIDTH) ? w_val : h_val;
    @(posedge clk_i);
    blur_board.apply_reg(first, (first == REG_FRAME_WIDTH) ? w_val : h_val);
    cfg_index_i <= second;
    cfg_wdata_i <= (second == REG_FRAME_WIDTH) ? w_val : h_val;
    @(posedge clk_i);
    blur_board.apply_reg(second, (second == REG_FRAME_WIDTH) ? w_val : h_val);
    cfg_we_i <= 1'b0;
  endtask

  // one frame of raster pixels and its tail of drains, sprinkled with items
  // the block must drop: early drains, pixels during the tail, a stray drain
  // after frame end. a cut frame stops part way and needs a restart after it
  task automatic run_frame(input int unsigned w_val, input int unsigned h_val,
                           input bit write_cfg, input bit cut_short, input bit flat);
    int unsigned     w, h, n_pix, i;
    logic [CH_W-1:0] level;
    if (write_cfg) set_frame_size(DIM_W'(w_val), DIM_W'(h_val));
    w     = blur_board.cols_in_use();
    h     = blur_board.rows_in_use();
    n_pix = w * h;
    if (cut_short) n_pix = $urandom_range(n_pix - 1);
    level = $urandom_range(1) ? '1 : '0;
    for (i = 0; i < n_pix; i++) begin
      if ($urandom_range(99) < 3) send_item(DRAIN_ITEM, pick_level(), pick_level(), pick_level());
      if (flat) send_item(PIXEL_ITEM, level, level, level);
      else send_item(PIXEL_ITEM, pick_level(), pick_level(), pick_level());
    end
    if (!cut_short) begin
      // one row plus one pixel of drains pushes the whole tail out
      for (i = 0; i <= w; i++) begin
        if ($urandom_range(99) < 3) begin
          send_item(PIXEL_ITEM, pick_level(), pick_level(), pick_level());
        end
        send_item(DRAIN_ITEM, pick_level(), pick_level(), pick_level());
      end
      if ($urandom_range(99) < 4) send_item(DRAIN_ITEM, pick_level(), pick_level(), pick_level());
    end
  endtask

  initial begin
    int unsigned     phase, fw, fh, shape, i;
    bit              need_cfg, cut;
    logic [CH_W-1:0] lvl;
    blur_board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // 3x3 frame: every window shape from corner to centre, uneven floors
    set_frame_size(13'd3, 13'd3);
    for (i = 0; i < 9; i++) begin
      if (i == 4) send_item(DRAIN_ITEM, '1, '1, '1);  // drain too early, dropped
      lvl = CH_W'(i * 31);
      send_item(PIXEL_ITEM, i[0] ? '1 : '0, i[1] ? '1 : '0, lvl);
    end
    send_item(PIXEL_ITEM, '1, '1, '1);  // pixel while the tail is pending, dropped
    for (i = 0; i < 4; i++) send_item(DRAIN_ITEM, '0, '0, '0);

    // zero width and height both act as one: a single-pixel frame
    set_frame_size('0, '0);
    send_item(PIXEL_ITEM, '1, '0, '1);
    send_item(DRAIN_ITEM, '1, '1, '1);
    send_item(DRAIN_ITEM, '0, '0, '0);

    // oversized registers, then a write part way in restarts the frame
    set_frame_size('1, '1);
    send_item(PIXEL_ITEM, '1, '1, '1);
    send_item(PIXEL_ITEM, '0, '0, '0);
    set_frame_size(13'd4096, 13'd1);
    send_item(PIXEL_ITEM, '1, '0, '0);

    // two pixels in a single row
    set_frame_size(13'd2, 13'd1);
    send_item(PIXEL_ITEM, '1, '1, '1);
    send_item(PIXEL_ITEM, 8'd1, 8'd0, 8'd254);
    for (i = 0; i < 3; i++) send_item(DRAIN_ITEM, '0, '0, '0);

    // ---- random frames, three idling phases ----
    need_cfg = 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 26;
          recv_gap_pct = 58;
        end
        1: begin
          send_gap_pct = 58;
          recv_gap_pct = 26;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      while (items_used < (phase + 1) * PHASE_ITEMS) begin
        shape = $urandom_range(99);
        if (shape < 70) begin
          fw = $urandom_range(1, 10);
          fh = $urandom_range(1, 6);
        end else if (shape < 85) begin
          fw = $urandom_range(11, 48);
          fh = $urandom_range(1, 3);
        end else if (shape < 92) begin
          // a zero register acts as one
          fw = $urandom_range(1) ? 0 : $urandom_range(1, 6);
          fh = (fw != 0 && $urandom_range(1)) ? $urandom_range(1, 5) : 0;
        end else begin
          // tall and narrow
          fw = $urandom_range(1, 4);
          fh = $urandom_range(10, 40);
        end
        cut = ($urandom_range(99) < 8);
        run_frame(fw, fh, need_cfg || ($urandom_range(99) < 75), cut, ($urandom_range(99) < 6));
        need_cfg = cut;
      end
    end

    settle();
    if (blur_board.mismatches == 0) begin
      $display("box_blur_3x3_rgb_core regression: pass");
    end else begin
      $display("box_blur_3x3_rgb_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/bbr_pkg.sv
hdl/bbr_line_ram.sv
hdl/box_blur_3x3_rgb_core.sv
hdl/bbr_checker.sv
sim/tb_box_blur_3x3_rgb_core.sv
